FILE: design/ogc_pkg.sv
package ogc_pkg;

	localparam int MAX_CELLS  = 65536;
	localparam int COUNT_BITS = 32;
	localparam int ADDR_W     = $clog2(MAX_CELLS);
	localparam int CNT_W      = COUNT_BITS;

	localparam logic [1:0] CLS_UNKNOWN  = 2'd0;
	localparam logic [1:0] CLS_OCCUPIED = 2'd1;
	localparam logic [1:0] CLS_FREE     = 2'd2;

	localparam logic [1:0] FUNC_PASS    = 2'd0;
	localparam logic [1:0] FUNC_HIT     = 2'd1;
	localparam logic [1:0] FUNC_REBUILD = 2'd2;

	localparam logic [1:0] CFG_GRID_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_GRID_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_MIN_PASS      = 2'd2;
	localparam logic [1:0] CFG_OCC_THRESHOLD = 2'd3;

	typedef struct packed {
		logic [1:0]       cls;
		logic [CNT_W-1:0] hit_cnt;
		logic [CNT_W-1:0] pass_cnt;
	} cell_t;

	typedef enum logic [1:0] {
		OP_PASS,
		OP_HIT,
		OP_KEEP,
		OP_REBUILD
	} op_t;

	typedef struct packed {
		op_t  op;
		logic upd;
	} cls_op_t;

endpackage

FILE: design/ogc_cell_ram.sv
module ogc_cell_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ogc_pkg::ADDR_W-1:0] waddr,
	input  ogc_pkg::cell_t            wdata,
	input  logic [ogc_pkg::ADDR_W-1:0] raddr,
	output ogc_pkg::cell_t            rdata
);

	ogc_pkg::cell_t mem [ogc_pkg::MAX_CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ogc_index.sv
module ogc_index (
	input  logic                       clk,
	input  logic                       load,
	input  logic signed [15:0]         cell_x,
	input  logic signed [15:0]         cell_y,
	input  logic [8:0]                 grid_width,
	input  logic [8:0]                 grid_height,
	output logic                       in_range,
	output logic [ogc_pkg::ADDR_W-1:0] idx
);

	localparam int SUM_W = 19;

	logic             x_ok;
	logic             y_ok;
	logic [17:0]      row_base;
	logic [SUM_W-1:0] sum;

	// Only the low nine bits of a coordinate matter once it is known to lie
	// below a nine-bit grid size.
	assign x_ok     = !cell_x[15] && ($unsigned(cell_x) < {7'd0, grid_width});
	assign y_ok     = !cell_y[15] && ($unsigned(cell_y) < {7'd0, grid_height});
	assign row_base = 18'(cell_y[8:0]) * 18'(grid_width);
	assign sum      = {1'b0, row_base} + {10'd0, cell_x[8:0]};

	always_ff @(posedge clk) begin
		if (load) begin
			in_range <= x_ok && y_ok && (32'(sum) < ogc_pkg::MAX_CELLS);
			idx      <= ogc_pkg::ADDR_W'(sum);
		end
	end

endmodule

FILE: design/ogc_classify.sv
module ogc_classify (
	input  logic             clk,
	input  logic             load,
	input  ogc_pkg::cls_op_t op,
	input  ogc_pkg::cell_t   rd_cell,
	input  logic [7:0]       min_pass,
	input  logic [15:0]      occ_threshold,
	output ogc_pkg::cell_t   new_cell
);

	localparam int PROD_W = ogc_pkg::CNT_W + 16;
	localparam logic [ogc_pkg::CNT_W-1:0] CNT_MAX = '1;

	logic                      count_op;
	logic [ogc_pkg::CNT_W-1:0] pass_s1;
	logic [ogc_pkg::CNT_W-1:0] hit_s1;
	logic [1:0]                cls_s1;
	logic                      run_s1;
	logic                      inc_s1;
	logic [PROD_W-1:0]         prod_s1;
	logic [PROD_W-1:0]         prod_adj;
	logic                      ratio_hi;
	logic                      enough;

	assign count_op = (op.op == ogc_pkg::OP_PASS) || (op.op == ogc_pkg::OP_HIT);

	// The product is taken on the old pass count; when the count moves up by
	// one, adding the threshold once more gives the product on the new count.
	always_ff @(posedge clk) begin
		if (load) begin
			inc_s1  <= count_op && (rd_cell.pass_cnt != CNT_MAX);
			pass_s1 <= (count_op && (rd_cell.pass_cnt != CNT_MAX)) ?
				rd_cell.pass_cnt + 1'b1 : rd_cell.pass_cnt;
			hit_s1  <= ((op.op == ogc_pkg::OP_HIT) && (rd_cell.hit_cnt != CNT_MAX)) ?
				rd_cell.hit_cnt + 1'b1 : rd_cell.hit_cnt;
			cls_s1  <= (op.op == ogc_pkg::OP_REBUILD) ? ogc_pkg::CLS_UNKNOWN : rd_cell.cls;
			run_s1  <= (op.op == ogc_pkg::OP_REBUILD) || (count_op && op.upd);
			prod_s1 <= PROD_W'(occ_threshold) * PROD_W'(rd_cell.pass_cnt);
		end
	end

	assign prod_adj = prod_s1 + (inc_s1 ? PROD_W'(occ_threshold) : PROD_W'(0));
	assign ratio_hi = {hit_s1, 16'd0} > prod_adj;
	assign enough   = pass_s1 > ogc_pkg::CNT_W'(min_pass);

	always_comb begin
		new_cell.pass_cnt = pass_s1;
		new_cell.hit_cnt  = hit_s1;
		new_cell.cls      = cls_s1;
		if (run_s1 && enough) begin
			new_cell.cls = ratio_hi ? ogc_pkg::CLS_OCCUPIED : ogc_pkg::CLS_FREE;
		end
	end

endmodule

FILE: design/occupancy_cell_count_classifier_unit.sv
// A cell event inside the grid goes through the dispatch, read, calculate and write-back states
// before its result is registered; one outside the grid goes from dispatch to write-back.
// No new event is taken until the last one has left write-back, which holds while the output is stalled.
// A rebuild first walks every cell with the same read, update and write-back steps.
// After reset a clearing pass zeroes every cell of the store; no event is taken
// meanwhile, configuration writes are. Registers take their documented reset values.
module occupancy_cell_count_classifier_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] cell_x,
	input  logic signed [15:0] cell_y,
	input  logic               update_now,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               in_grid,
	output logic [1:0]         cell_class,
	output logic [31:0]        pass_total,
	output logic [31:0]        hit_total
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_DISP,
		S_SW_RD,
		S_SW_CALC,
		S_SW_WR,
		S_RD,
		S_CALC,
		S_WRB
	} state_t;

	localparam logic [ogc_pkg::ADDR_W-1:0] LAST_ADDR = ogc_pkg::ADDR_W'(ogc_pkg::MAX_CELLS - 1);

	state_t                     state_q;
	logic [ogc_pkg::ADDR_W-1:0] cnt_q;
	logic [1:0]                 func_q;
	logic                       upd_q;
	logic                       rsp_valid_q;
	logic                       in_grid_q;
	logic [1:0]                 cls_q;
	logic [31:0]                pass_q;
	logic [31:0]                hit_q;

	logic [8:0]  grid_width_q;
	logic [8:0]  grid_height_q;
	logic [7:0]  min_pass_q;
	logic [15:0] occ_threshold_q;

	logic                       accept;
	logic                       out_free;
	logic                       in_range;
	logic [ogc_pkg::ADDR_W-1:0] idx;
	ogc_pkg::cls_op_t           op;
	ogc_pkg::cell_t             rd_cell;
	ogc_pkg::cell_t             new_cell;
	ogc_pkg::cell_t             wr_cell;
	logic                       ram_we;
	logic [ogc_pkg::ADDR_W-1:0] ram_waddr;
	logic [ogc_pkg::ADDR_W-1:0] ram_raddr;
	logic                       calc_load;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid  = rsp_valid_q;
	assign in_grid    = in_grid_q;
	assign cell_class = cls_q;
	assign pass_total = pass_q;
	assign hit_total  = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= 9'd256;
			grid_height_q   <= 9'd256;
			min_pass_q      <= 8'd2;
			occ_threshold_q <= 16'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				ogc_pkg::CFG_GRID_WIDTH:    grid_width_q    <= cfg_data[8:0];
				ogc_pkg::CFG_GRID_HEIGHT:   grid_height_q   <= cfg_data[8:0];
				ogc_pkg::CFG_MIN_PASS:      min_pass_q      <= cfg_data[7:0];
				ogc_pkg::CFG_OCC_THRESHOLD: occ_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		op.upd = upd_q;
		if (state_q == S_SW_RD || state_q == S_SW_CALC || state_q == S_SW_WR) begin
			op.op = ogc_pkg::OP_REBUILD;
		end else begin
			case (func_q)
				ogc_pkg::FUNC_PASS: op.op = ogc_pkg::OP_PASS;
				ogc_pkg::FUNC_HIT:  op.op = ogc_pkg::OP_HIT;
				default:            op.op = ogc_pkg::OP_KEEP;
			endcase
		end
	end

	assign calc_load = (state_q == S_CALC) || (state_q == S_SW_CALC);
	assign ram_raddr = (state_q == S_SW_RD) ? cnt_q : idx;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx;
		wr_cell   = new_cell;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				wr_cell   = '0;
			end
			S_SW_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
			end
			S_WRB: begin
				// Written at most once, on the cycle the result goes to the output register.
				ram_we = in_range && out_free && (op.op != ogc_pkg::OP_KEEP);
			end
			default: ;
		endcase
	end

	ogc_index u_index (
		.clk         (clk),
		.load        (accept),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.in_range    (in_range),
		.idx         (idx)
	);

	ogc_cell_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_cell),
		.raddr (ram_raddr),
		.rdata (rd_cell)
	);

	ogc_classify u_classify (
		.clk           (clk),
		.load          (calc_load),
		.op            (op),
		.rd_cell       (rd_cell),
		.min_pass      (min_pass_q),
		.occ_threshold (occ_threshold_q),
		.new_cell      (new_cell)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			func_q      <= ogc_pkg::FUNC_PASS;
			upd_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			in_grid_q   <= 1'b0;
			cls_q       <= ogc_pkg::CLS_UNKNOWN;
			pass_q      <= '0;
			hit_q       <= '0;
		end else begin
			if (state_q == S_WRB && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (cnt_q == LAST_ADDR) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						func_q  <= func;
						upd_q   <= update_now;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (func_q == ogc_pkg::FUNC_REBUILD) begin
						cnt_q   <= '0;
						state_q <= S_SW_RD;
					end else if (in_range) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_WRB;
					end
				end
				S_SW_RD:   state_q <= S_SW_CALC;
				S_SW_CALC: state_q <= S_SW_WR;
				S_SW_WR: begin
					if (cnt_q == LAST_ADDR) begin
						cnt_q   <= '0;
						state_q <= in_range ? S_RD : S_WRB;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_SW_RD;
					end
				end
				S_RD:   state_q <= S_CALC;
				S_CALC: state_q <= S_WRB;
				S_WRB: begin
					if (out_free) begin
						in_grid_q <= in_range;
						cls_q     <= in_range ? new_cell.cls : ogc_pkg::CLS_UNKNOWN;
						pass_q    <= in_range ? 32'(new_cell.pass_cnt) : 32'd0;
						hit_q     <= in_range ? 32'(new_cell.hit_cnt) : 32'd0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DISP))
		else $error("accepted transaction did not reach dispatch");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRB && !out_free) |=> (state_q == S_WRB))
		else $error("result dropped while output register was full");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRB && out_free && !in_range) |=>
			(rsp_valid && !in_grid && cell_class == ogc_pkg::CLS_UNKNOWN &&
			 pass_total == 32'd0 && hit_total == 32'd0))
		else $error("cell outside the grid reported nonzero fields");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 600000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 12;
	localparam int IDLE_PCT       = 36;
	localparam int REPORT_LIMIT   = 10;
	localparam int HOT_CELLS      = 4;
	localparam int PHASE_ITEMS    = 60;
	localparam int RANDOM_PHASES  = 7;

	typedef struct packed {
		logic                      in_grid;
		logic [1:0]                cls;
		logic [ogc_pkg::CNT_W-1:0] pass_cnt;
		logic [ogc_pkg::CNT_W-1:0] hit_cnt;
	} cell_report_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         func;
	logic signed [15:0] cell_x;
	logic signed [15:0] cell_y;
	logic               update_now;
	logic               rsp_valid;
	logic               rsp_stall;
	logic               in_grid;
	logic [1:0]         cell_class;
	logic [31:0]        pass_total;
	logic [31:0]        hit_total;

	// Shadow copy of the cell store and of the registers, kept in step with
	// every accepted transaction and every register write.
	bit [ogc_pkg::CNT_W-1:0] grid_pass [ogc_pkg::MAX_CELLS];
	bit [ogc_pkg::CNT_W-1:0] grid_hits [ogc_pkg::MAX_CELLS];
	bit [1:0]                grid_cls  [ogc_pkg::MAX_CELLS];
	logic [8:0]     cur_width;
	logic [8:0]     cur_height;
	logic [7:0]     cur_min_pass;
	logic [15:0]    cur_threshold;

	cell_report_t pending_reports[$];
	int failures = 0;
	bit no_idle = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	logic signed [15:0] hot_x [HOT_CELLS];
	logic signed [15:0] hot_y [HOT_CELLS];
	int hit_pct;

	occupancy_cell_count_classifier_unit i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void reclassify(int idx);
		logic [63:0] p;
		logic [63:0] h;
		p = 64'(grid_pass[idx]);
		h = 64'(grid_hits[idx]);
		if (p > 64'(cur_min_pass)) begin
			if ((h << 16) > 64'(cur_threshold) * p)
				grid_cls[idx] = ogc_pkg::CLS_OCCUPIED;
			else
				grid_cls[idx] = ogc_pkg::CLS_FREE;
		end
	endfunction

	function automatic cell_report_t predict_event(logic [1:0] f, logic signed [15:0] x,
			logic signed [15:0] y, logic upd);
		cell_report_t rep;
		int xi;
		int yi;
		longint idx;
		bit in_range;
		xi = x;
		yi = y;
		idx = 0;
		in_range = 1'b0;
		if (xi >= 0 && yi >= 0 && xi < int'(cur_width) && yi < int'(cur_height)) begin
			idx = longint'(yi) * longint'(cur_width) + xi;
			in_range = idx < ogc_pkg::MAX_CELLS;
		end
		if (f == ogc_pkg::FUNC_REBUILD) begin
			for (int i = 0; i < ogc_pkg::MAX_CELLS; i++) begin
				grid_cls[i] = ogc_pkg::CLS_UNKNOWN;
				reclassify(i);
			end
		end else if (in_range && (f == ogc_pkg::FUNC_PASS || f == ogc_pkg::FUNC_HIT)) begin
			if (grid_pass[idx] != '1)
				grid_pass[idx] = grid_pass[idx] + 1;
			if (f == ogc_pkg::FUNC_HIT && grid_hits[idx] != '1)
				grid_hits[idx] = grid_hits[idx] + 1;
			if (upd)
				reclassify(int'(idx));
		end
		rep = '0;
		if (in_range) begin
			rep.in_grid  = 1'b1;
			rep.cls      = grid_cls[idx];
			rep.pass_cnt = grid_pass[idx];
			rep.hit_cnt  = grid_hits[idx];
		end
		return rep;
	endfunction

	// Offers one cell event and leaves valid high after acceptance, so that
	// back-to-back transactions keep valid up without a glitch.
	task automatic send_event(input logic [1:0] f, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic upd);
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid  <= 1'b1;
		func       <= f;
		cell_x     <= x;
		cell_y     <= y;
		update_now <= upd;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_reports = {pending_reports, predict_event(f, x, y, upd)};
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			ogc_pkg::CFG_GRID_WIDTH:    cur_width = value[8:0];
			ogc_pkg::CFG_GRID_HEIGHT:   cur_height = value[8:0];
			ogc_pkg::CFG_MIN_PASS:      cur_min_pass = value[7:0];
			ogc_pkg::CFG_OCC_THRESHOLD: cur_threshold = value;
			default: ;
		endcase
	endtask

	// Unused upper bits of the write data carry random junk; the block must
	// ignore them.
	task automatic configure(input logic [8:0] w, input logic [8:0] h, input logic [7:0] mp,
			input logic [15:0] thr);
		logic [15:0] junk;
		wait_idle();
		junk = 16'($urandom);
		cfg_put(ogc_pkg::CFG_GRID_WIDTH, {junk[15:9], w});
		cfg_put(ogc_pkg::CFG_GRID_HEIGHT, {junk[6:0], h});
		cfg_put(ogc_pkg::CFG_MIN_PASS, {junk[15:8], mp});
		cfg_put(ogc_pkg::CFG_OCC_THRESHOLD, thr);
		cfg_we <= 1'b0;
	endtask

	// A few cells get most of the traffic so that their counts climb past
	// min_pass and the ratio test actually decides the class.
	function automatic void pick_hot_cells();
		for (int k = 0; k < HOT_CELLS; k++) begin
			hot_x[k] = (cur_width == 0) ? 16'sd0 : 16'($urandom_range(cur_width - 1));
			hot_y[k] = (cur_height == 0) ? 16'sd0 : 16'($urandom_range(cur_height - 1));
		end
		hit_pct = $urandom_range(100);
	endfunction

	task automatic send_random_event();
		int r;
		int k;
		logic [1:0] f;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic upd;
		r = $urandom_range(99);
		k = $urandom_range(HOT_CELLS - 1);
		upd = 1'($urandom_range(1));
		x = hot_x[k];
		y = hot_y[k];
		f = ($urandom_range(99) < hit_pct) ? ogc_pkg::FUNC_HIT : ogc_pkg::FUNC_PASS;
		if (r < 75) begin
			upd = $urandom_range(99) < 70;
		end else if (r < 85) begin
			x = (cur_width == 0) ? 16'sd0 : 16'($urandom_range(cur_width - 1));
			y = (cur_height == 0) ? 16'sd0 : 16'($urandom_range(cur_height - 1));
		end else if (r < 95) begin
			x = 16'($urandom);
			y = 16'($urandom);
			case ($urandom_range(2))
				0: f = ogc_pkg::FUNC_PASS;
				1: f = ogc_pkg::FUNC_HIT;
				default: f = FUNC_UNUSED;
			endcase
		end else begin
			f = FUNC_UNUSED;
		end
		send_event(f, x, y, upd);
	endtask

	task automatic test_directed_cells();
		configure(9'd4, 9'd3, 8'd0, 16'd32768);
		send_event(ogc_pkg::FUNC_PASS, 16'sd0, 16'sd0, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd0, 16'sd0, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd0, 16'sd0, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd3, 16'sd2, 1'b0);
		send_event(ogc_pkg::FUNC_PASS, 16'sd3, 16'sd2, 1'b1);
		send_event(ogc_pkg::FUNC_PASS, 16'sd4, 16'sd0, 1'b1);
		send_event(ogc_pkg::FUNC_PASS, 16'sd0, 16'sd3, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, -16'sd1, 16'sd0, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd0, -16'sd32768, 1'b1);
		send_event(ogc_pkg::FUNC_PASS, 16'sd32767, 16'sd32767, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, -16'sd32768, -16'sd1, 1'b1);
		send_event(FUNC_UNUSED, 16'sd0, 16'sd0, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd1, 16'sd1, 1'b0);
		// Rebuild wipes every class and reclassifies from the counts alone.
		send_event(ogc_pkg::FUNC_REBUILD, 16'sd1, 16'sd1, 1'b0);
		send_event(ogc_pkg::FUNC_PASS, 16'sd2, 16'sd1, 1'b0);
	endtask

	task automatic test_grid_size_edges();
		configure(9'd0, 9'd3, 8'd0, 16'd32768);
		send_event(ogc_pkg::FUNC_PASS, 16'sd0, 16'sd0, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd0, 16'sd0, 1'b1);
		configure(9'd4, 9'd0, 8'd0, 16'd32768);
		send_event(ogc_pkg::FUNC_PASS, 16'sd0, 16'sd0, 1'b1);
		// With 511 columns the flat index runs past the store for high rows.
		configure(9'd511, 9'd511, 8'd0, 16'd32768);
		send_event(ogc_pkg::FUNC_PASS, 16'sd510, 16'sd200, 1'b1);
		send_event(ogc_pkg::FUNC_PASS, 16'sd300, 16'sd100, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd255, 16'sd128, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd0, 16'sd128, 1'b1);
		send_event(ogc_pkg::FUNC_HIT, 16'sd510, 16'sd127, 1'b1);
	endtask

	task automatic test_full_rate();
		configure(9'd8, 9'd8, 8'd1, 16'd16384);
		pick_hot_cells();
		no_idle = 1'b1;
		for (int n = 0; n < PHASE_ITEMS; n++)
			send_random_event();
		wait_idle();
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		configure(9'd64, 9'd64, 8'd2, 16'd6554);
		pick_hot_cells();
		hold_requests++;
		for (int n = 0; n < PHASE_ITEMS; n++)
			send_random_event();
	endtask

	task automatic test_random_settings();
		int rebuild_at;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: configure(9'd256, 9'd256, 8'd2, 16'd6554);
				1: configure(9'd1, 9'd1, 8'd0, 16'd0);
				2: configure(9'd16, 9'd8, 8'd255, 16'd65535);
				3: configure(9'd5, 9'd300, 8'd1, 16'd20000);
				4: configure(9'd256, 9'd256, 8'd0, 16'd65535);
				5: configure(9'd300, 9'd256, 8'd3, 16'd40000);
				default: configure(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
						8'($urandom_range(8)), 16'($urandom));
			endcase
			pick_hot_cells();
			rebuild_at = (p == 1 || p == 4) ? $urandom_range(PHASE_ITEMS - 1) : -1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == rebuild_at)
					send_event(ogc_pkg::FUNC_REBUILD, 16'($urandom), 16'($urandom),
						1'($urandom));
				else
					send_random_event();
			end
		end
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
			rsp_stall   <= 1'b1;
		end else begin
			rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin : check_reports
		cell_report_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_reports.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: in_grid %0d class %0d pass %0d hit %0d",
						in_grid, cell_class, pass_total, hit_total);
			end else begin
				want = pending_reports.pop_front();
				if (in_grid !== want.in_grid || cell_class !== want.cls ||
						pass_total !== want.pass_cnt || hit_total !== want.hit_cnt) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.in_grid, want.cls, want.pass_cnt, want.hit_cnt,
							in_grid, cell_class, pass_total, hit_total);
				end
			end
		end
	end

	// A rebuild sweep or the clearing pass accepts nothing for a long time;
	// the limit sits well above both.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= ogc_pkg::CFG_GRID_WIDTH;
		cfg_data      <= '0;
		req_valid     <= 1'b0;
		func          <= ogc_pkg::FUNC_PASS;
		cell_x        <= '0;
		cell_y        <= '0;
		update_now    <= 1'b0;
		rsp_stall     <= 1'b0;
		cur_width     = 9'd256;
		cur_height    = 9'd256;
		cur_min_pass  = 8'd2;
		cur_threshold = 16'd6554;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cells();
		test_grid_size_edges();
		test_full_rate();
		test_backpressure();
		test_random_settings();
		wait_idle();
		if (failures == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: sim.f
design/ogc_pkg.sv
design/ogc_cell_ram.sv
design/ogc_index.sv
design/ogc_classify.sv
design/occupancy_cell_count_classifier_unit.sv
bench/tb_top.sv
